>>> hw/rtl/pcm_pkg.sv
`timescale 1ns / 1ps

package pcm_pkg;

  // Capacity of one patch in pixels (1 to 4096)
  localparam int MAX_SAMPLES = 256;
  localparam int CNT_W       = $clog2(MAX_SAMPLES + 1);
  localparam int BIN_W       = 8;
  localparam int NUM_BINS    = 1 << BIN_W;
  localparam int NUM_CH      = 3;

  typedef struct packed {
    logic [BIN_W-1:0] chan0;
    logic [BIN_W-1:0] chan1;
    logic [BIN_W-1:0] chan2;
    logic             last_pixel;
  } pcm_in_t;

  typedef struct packed {
    logic [BIN_W-1:0] median0;
    logic [BIN_W-1:0] median1;
    logic [BIN_W-1:0] median2;
    logic             patch_empty;
    logic             sample_overflow;
  } pcm_out_t;

  // Controller to datapath
  typedef struct packed {
    logic accept;      // pixel transfer this cycle
    logic clear_sweep; // write zero at sweep address, no walk
    logic walk_sweep;  // read and zero at sweep address, walk
    logic walk_start;  // capture count, restart walk state
    logic load_out;    // load result register
  } pcm_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic sweep_end;   // sweep address at last bin
  } pcm_sts_t;

endpackage

>>> hw/rtl/patch_channel_median_core.sv
`timescale 1ns / 1ps

// Lower median of each of three colour channels over a sample patch.
//
// Input channel (in_valid / in_ready / in_data): one pixel per transfer,
// three 8-bit channels plus a last_pixel mark on the final pixel of the
// patch. Pixels beyond MAX_SAMPLES are dropped and flagged as overflow.
// Result channel (out_valid / out_ready / out_data): one transfer per
// patch, carrying the three medians (sorted index (n-1)/2), patch_empty
// and sample_overflow.
//
// Throughput: one pixel per cycle while a patch streams in. After the
// last pixel the block walks all 256 bins of its three histogram RAMs,
// zeroing each bin as it reads it, and then loads the result; in_ready
// is low for that walk.
//
// Reset: a clearing pass zeroes the histogram RAMs; in_ready stays low
// until it completes.
// Stall: the result sits in an output register; the next patch streams in
// meanwhile, and only its own result load waits for out_ready.

module patch_channel_median_core (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  pcm_pkg::pcm_in_t  in_data,
  output logic              out_valid,
  input  logic              out_ready,
  output pcm_pkg::pcm_out_t out_data
);

  import pcm_pkg::*;

  pcm_cmd_t cmd;
  pcm_sts_t sts;

  pcm_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_last   (in_data.last_pixel),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  pcm_dpath u_dpath (
    .clk      (clk),
    .rst_n    (rst_n),
    .cmd      (cmd),
    .in_data  (in_data),
    .sts      (sts),
    .out_data (out_data)
  );

  // The RAM write port is never shared between pixel updates and a sweep
  assert property (@(posedge clk) disable iff (!rst_n)
    cmd.accept |-> !(cmd.clear_sweep || cmd.walk_sweep))
    else $error("pixel transfer during histogram sweep");

  // A pending result is never overwritten
  assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load_out |-> (!out_valid || out_ready))
    else $error("result register overwritten before transfer");

  // After the last pixel, input closes until the walk is done
  assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready && in_data.last_pixel) |=> !in_ready)
    else $error("input open after last pixel");

  // Walk follows its start directly
  assert property (@(posedge clk) disable iff (!rst_n)
    cmd.walk_start |=> (cmd.walk_sweep && !in_ready))
    else $error("walk did not begin after capture");

endmodule

>>> hw/rtl/pcm_ram.sv
`timescale 1ns / 1ps

module pcm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  // read-first: a read at the written address returns the old word
  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rd_data_r <= mem_r[raddr];
  end

  assign rdata = rd_data_r;

endmodule

>>> hw/rtl/pcm_dpath.sv
`timescale 1ns / 1ps

module pcm_dpath (
  input  logic              clk,
  input  logic              rst_n,
  input  pcm_pkg::pcm_cmd_t cmd,
  input  pcm_pkg::pcm_in_t  in_data,
  output pcm_pkg::pcm_sts_t sts,
  output pcm_pkg::pcm_out_t out_data
);

  import pcm_pkg::*;

  logic [BIN_W-1:0] pix_bin [NUM_CH];
  logic [BIN_W-1:0] rd_addr [NUM_CH];
  logic [BIN_W-1:0] wr_addr [NUM_CH];
  logic [CNT_W-1:0] wr_data [NUM_CH];
  logic [CNT_W-1:0] rd_data [NUM_CH];
  logic [CNT_W-1:0] inc     [NUM_CH];
  logic [CNT_W-1:0] cum_sum [NUM_CH];
  logic             wr_en;
  logic             sweeping;
  logic             take;

  // accumulate stage
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             ovf_r, ovf_nxt;
  logic             s1_we_r, s1_we_nxt;
  logic [BIN_W-1:0] s1_bin_r [NUM_CH];
  logic [BIN_W-1:0] s1_bin_nxt [NUM_CH];
  logic             pw_valid_r;
  logic [BIN_W-1:0] pw_addr_r [NUM_CH];
  logic [CNT_W-1:0] pw_data_r [NUM_CH];

  // walk stage
  logic [BIN_W-1:0] sweep_addr_r, sweep_addr_nxt;
  logic             wk_valid_r;
  logic [BIN_W-1:0] wk_bin_r;
  logic [CNT_W-1:0] idx_r;
  logic             empty_r;
  logic             ovf_cap_r;
  logic [CNT_W-1:0] cum_r   [NUM_CH];
  logic [CNT_W-1:0] cum_nxt [NUM_CH];
  logic             found_r   [NUM_CH];
  logic             found_nxt [NUM_CH];
  logic [BIN_W-1:0] med_r   [NUM_CH];
  logic [BIN_W-1:0] med_nxt [NUM_CH];
  pcm_out_t         out_r;

  assign pix_bin[0] = in_data.chan0;
  assign pix_bin[1] = in_data.chan1;
  assign pix_bin[2] = in_data.chan2;

  assign sweeping = cmd.clear_sweep | cmd.walk_sweep;
  assign take     = cnt_r < CNT_W'(MAX_SAMPLES);
  assign wr_en    = sweeping | s1_we_r;
  assign sts.sweep_end = (sweep_addr_r == BIN_W'(NUM_BINS - 1));

  for (genvar c = 0; c < NUM_CH; c++) begin : g_ch
    // forward the previous write, which the read at that edge missed
    assign inc[c] = ((pw_valid_r && (pw_addr_r[c] == s1_bin_r[c])) ?
                     pw_data_r[c] : rd_data[c]) + CNT_W'(1);
    assign rd_addr[c] = sweeping ? sweep_addr_r : pix_bin[c];
    assign wr_addr[c] = sweeping ? sweep_addr_r : s1_bin_r[c];
    assign wr_data[c] = sweeping ? '0 : inc[c];
    assign cum_sum[c] = cum_r[c] + rd_data[c];

    pcm_ram #(
      .WIDTH (CNT_W),
      .DEPTH (NUM_BINS)
    ) u_hist (
      .clk   (clk),
      .we    (wr_en),
      .waddr (wr_addr[c]),
      .wdata (wr_data[c]),
      .raddr (rd_addr[c]),
      .rdata (rd_data[c])
    );
  end

  always_comb begin
    cnt_nxt        = cnt_r;
    ovf_nxt        = ovf_r;
    s1_we_nxt      = 1'b0;
    sweep_addr_nxt = sweep_addr_r;
    for (int c = 0; c < NUM_CH; c++) begin
      s1_bin_nxt[c] = pix_bin[c];
      cum_nxt[c]    = cum_r[c];
      found_nxt[c]  = found_r[c];
      med_nxt[c]    = med_r[c];
    end

    if (cmd.accept) begin
      if (take) begin
        cnt_nxt   = cnt_r + CNT_W'(1);
        s1_we_nxt = 1'b1;
      end else begin
        ovf_nxt = 1'b1;
      end
    end

    if (sweeping) begin
      sweep_addr_nxt = sweep_addr_r + BIN_W'(1);
    end

    if (wk_valid_r) begin
      for (int c = 0; c < NUM_CH; c++) begin
        cum_nxt[c] = cum_sum[c];
        if (!found_r[c] && (cum_sum[c] > idx_r)) begin
          found_nxt[c] = 1'b1;
          med_nxt[c]   = wk_bin_r;
        end
      end
    end

    if (cmd.walk_start) begin
      cnt_nxt        = '0;
      ovf_nxt        = 1'b0;
      sweep_addr_nxt = '0;
      for (int c = 0; c < NUM_CH; c++) begin
        cum_nxt[c]   = '0;
        found_nxt[c] = 1'b0;
        med_nxt[c]   = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r        <= '0;
      ovf_r        <= 1'b0;
      s1_we_r      <= 1'b0;
      pw_valid_r   <= 1'b0;
      sweep_addr_r <= '0;
      wk_valid_r   <= 1'b0;
    end else begin
      cnt_r        <= cnt_nxt;
      ovf_r        <= ovf_nxt;
      s1_we_r      <= s1_we_nxt;
      pw_valid_r   <= s1_we_r;
      sweep_addr_r <= sweep_addr_nxt;
      wk_valid_r   <= cmd.walk_sweep;
    end
  end

  always_ff @(posedge clk) begin
    for (int c = 0; c < NUM_CH; c++) begin
      s1_bin_r[c]  <= s1_bin_nxt[c];
      pw_addr_r[c] <= s1_bin_r[c];
      pw_data_r[c] <= inc[c];
      cum_r[c]     <= cum_nxt[c];
      found_r[c]   <= found_nxt[c];
      med_r[c]     <= med_nxt[c];
    end
    wk_bin_r <= sweep_addr_r;
    if (cmd.walk_start) begin
      idx_r     <= (cnt_r - CNT_W'(1)) >> 1;
      empty_r   <= (cnt_r == '0);
      ovf_cap_r <= ovf_r;
    end
    if (cmd.load_out) begin
      out_r.median0         <= med_r[0];
      out_r.median1         <= med_r[1];
      out_r.median2         <= med_r[2];
      out_r.patch_empty     <= empty_r;
      out_r.sample_overflow <= ovf_cap_r;
    end
  end

  assign out_data = out_r;

endmodule

>>> hw/rtl/pcm_ctrl.sv
`timescale 1ns / 1ps

module pcm_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  logic              in_last,
  output logic              in_ready,
  output logic              out_valid,
  input  logic              out_ready,
  input  pcm_pkg::pcm_sts_t sts,
  output pcm_pkg::pcm_cmd_t cmd
);

  import pcm_pkg::*;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_ACC,
    S_LASTW,
    S_WALK,
    S_DRAIN,
    S_FIN
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   accept;

  assign in_ready = (state_r == S_ACC);
  assign accept   = in_valid & in_ready;

  always_comb begin
    state_nxt       = state_r;
    cmd             = '0;
    cmd.accept      = accept;
    out_valid_nxt   = out_valid_r & ~out_ready;
    unique case (state_r)
      S_CLEAR: begin
        cmd.clear_sweep = 1'b1;
        if (sts.sweep_end) state_nxt = S_ACC;
      end
      S_ACC: begin
        if (accept && in_last) state_nxt = S_LASTW;
      end
      S_LASTW: begin
        cmd.walk_start = 1'b1;
        state_nxt      = S_WALK;
      end
      S_WALK: begin
        cmd.walk_sweep = 1'b1;
        if (sts.sweep_end) state_nxt = S_DRAIN;
      end
      S_DRAIN: begin
        state_nxt = S_FIN;
      end
      S_FIN: begin
        if (!out_valid_r || out_ready) begin
          cmd.load_out  = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = S_ACC;
        end
      end
      default: begin
        state_nxt = S_CLEAR;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

endmodule

>>> verif/tb.sv
`timescale 1ns / 1ps

// Checks patch_channel_median_core against its own histogram tally. Every
// accepted pixel transfer feeds the tally; a pixel carrying the last mark
// turns it into the expected per-channel lower medians, which queue up
// until the matching result transfer arrives. Every field of every result
// is compared against the oldest queued expectation.

module tb;
  import pcm_pkg::*;

  localparam int CLK_HALF    = 10;
  localparam int RST_CYCLES  = 8;
  // Long enough for a full bin walk, with some slack on top.
  localparam int WALK_CYCLES = 300;
  // Long enough for two walks to finish, so the input side backs up.
  localparam int HOLD_CYCLES = 2000;
  // Worst case is every transfer closing a patch and waiting out a full
  // walk plus receiver stalls; this covers that several times over.
  localparam longint CYCLE_LIMIT = 2_000_000;

  logic     clk       = 1'b0;
  logic     rst_n     = 1'b0;
  logic     in_valid  = 1'b0;
  logic     in_ready;
  pcm_in_t  in_data   = '0;
  logic     out_valid;
  logic     out_ready = 1'b0;
  pcm_out_t out_data;

  patch_channel_median_core uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  always #CLK_HALF clk = ~clk;

  // Tally of the patch in progress, one histogram per colour channel.
  int unsigned bin_tally [NUM_CH][NUM_BINS];
  int unsigned accepted_px  = 0;
  bit          overflow_px  = 1'b0;
  pcm_out_t    expected_medians [$];

  // Idle rates in percent, and a receiver hold-off request in cycles.
  int unsigned send_gap_pct = 15;
  int unsigned recv_gap_pct = 45;
  int unsigned hold_request = 0;
  int unsigned hold_left    = 0;
  int unsigned mismatches   = 0;
  longint      cycle_no     = 0;

  // ---------------------------------------------------------------------
  // Tally one accepted pixel; on the last mark, work out the result and
  // clear everything for the next patch.
  // ---------------------------------------------------------------------
  function automatic void tally_pixel(input pcm_in_t px);
    logic [BIN_W-1:0] lvl [NUM_CH];
    logic [BIN_W-1:0] med [NUM_CH];
    int unsigned      idx;
    int unsigned      run;
    int               c;
    int               b;
    bit               found;
    pcm_out_t         res;
    lvl[0] = px.chan0;
    lvl[1] = px.chan1;
    lvl[2] = px.chan2;
    // Full patch: the pixel is dropped but remembered as overflow, even
    // when it is the one carrying the last mark.
    if (accepted_px < MAX_SAMPLES) begin
      for (c = 0; c < NUM_CH; c++) begin
        bin_tally[c][lvl[c]]++;
      end
      accepted_px++;
    end else begin
      overflow_px = 1'b1;
    end
    if (!px.last_pixel) begin
      return;
    end
    res = '0;
    if (accepted_px == 0) begin
      // Empty patch: zero medians, flagged. Unreachable while the first
      // pixel of a patch always fits, kept for completeness.
      res.patch_empty = 1'b1;
    end else begin
      // Lower median sits at sorted index (n-1)/2: first bin whose running
      // total passes that index.
      idx = (accepted_px - 1) / 2;
      for (c = 0; c < NUM_CH; c++) begin
        run   = 0;
        found = 1'b0;
        med[c] = '0;
        for (b = 0; b < NUM_BINS; b++) begin
          run += bin_tally[c][b];
          if (!found && run > idx) begin
            med[c] = b[BIN_W-1:0];
            found  = 1'b1;
          end
        end
      end
      res.median0 = med[0];
      res.median1 = med[1];
      res.median2 = med[2];
    end
    res.sample_overflow = overflow_px;
    expected_medians.insert(expected_medians.size(), res);
    for (c = 0; c < NUM_CH; c++) begin
      for (b = 0; b < NUM_BINS; b++) begin
        bin_tally[c][b] = 0;
      end
    end
    accepted_px = 0;
    overflow_px = 1'b0;
  endfunction

  function automatic pcm_in_t pixel(input logic [BIN_W-1:0] c0, c1, c2, input logic last);
    pcm_in_t p;
    p.chan0      = c0;
    p.chan1      = c1;
    p.chan2      = c2;
    p.last_pixel = last;
    return p;
  endfunction

  function automatic void check_field(input string name, input int unsigned want,
                                      input int unsigned got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
      mismatches++;
    end
  endfunction

  // ---------------------------------------------------------------------
  // Receiver: random idling, or a counted hold-off when a test asks.
  // ---------------------------------------------------------------------
  always @(posedge clk) begin
    if (hold_request != 0) begin
      hold_left    = hold_request;
      hold_request = 0;
    end
    if (hold_left != 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_gap_pct);
    end
  end

  // Result check: each result transfer against the oldest expectation.
  always @(posedge clk) begin : result_check
    pcm_out_t want;
    if (rst_n && out_valid && out_ready) begin
      if (expected_medians.size() == 0) begin
        $display("%0t: unexpected result transfer, expected none, got %h",
                 $time, out_data);
        mismatches++;
      end else begin
        want = expected_medians.pop_front();
        check_field("median0", 32'(want.median0), 32'(out_data.median0));
        check_field("median1", 32'(want.median1), 32'(out_data.median1));
        check_field("median2", 32'(want.median2), 32'(out_data.median2));
        check_field("patch_empty", 32'(want.patch_empty),
                    32'(out_data.patch_empty));
        check_field("sample_overflow", 32'(want.sample_overflow),
                    32'(out_data.sample_overflow));
      end
    end
  end

  // Watchdog; also catches results that never come.
  always @(posedge clk) begin
    cycle_no++;
    if (cycle_no > CYCLE_LIMIT) begin
      $display("%0t: timed out, %0d results outstanding", $time,
               expected_medians.size());
      $display("** patch_channel_median_core: FAILED **");
      $finish;
    end
  end

  // ---------------------------------------------------------------------
  // Sender. Called at a rising edge; returns at the edge of the transfer.
  // ---------------------------------------------------------------------
  task automatic send_pixel(input pcm_in_t px);
    while ($urandom_range(99) < send_gap_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= px;
    @(posedge clk);
    while (!in_ready) begin
      @(posedge clk);
    end
    tally_pixel(px);
  endtask

  // Sender goes quiet until every expected result has been taken.
  task automatic wait_results_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (expected_medians.size() != 0) begin
      @(posedge clk);
    end
  endtask

  // One patch of random pixels; each channel clusters within spread of
  // its own base level (255 gives full range, 0 a flat channel).
  task automatic send_patch(input int unsigned len, input int unsigned spread);
    logic [BIN_W-1:0] base [NUM_CH];
    logic [BIN_W-1:0] lvl  [NUM_CH];
    int unsigned      i;
    int               c;
    for (c = 0; c < NUM_CH; c++) begin
      base[c] = BIN_W'($urandom_range(NUM_BINS - 1));
    end
    for (i = 0; i < len; i++) begin
      for (c = 0; c < NUM_CH; c++) begin
        lvl[c] = BIN_W'(base[c] + $urandom_range(spread));
      end
      send_pixel(pixel(lvl[0], lvl[1], lvl[2], i == len - 1));
    end
  endtask

  // ---------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------

  // One-pixel patches: the median is the pixel itself; extremes and
  // alternating bit or bit-pair patterns on every channel.
  task automatic test_single_pixel_patches();
    send_pixel(pixel(8'h00, 8'h00, 8'h00, 1'b1));
    send_pixel(pixel(8'hFF, 8'hFF, 8'hFF, 1'b1));
    send_pixel(pixel(8'h00, 8'hFF, 8'h80, 1'b1));
    send_pixel(pixel(8'hFF, 8'h01, 8'h7F, 1'b1));
    send_pixel(pixel(8'h55, 8'hAA, 8'h33, 1'b1));
    send_pixel(pixel(8'hAA, 8'h55, 8'hCC, 1'b1));
    wait_results_drained();
  endtask

  // Even counts: lower median must pick the smaller of the middle pair.
  task automatic test_even_patches();
    send_pixel(pixel(8'd10,  8'd255, 8'd0,   1'b0));
    send_pixel(pixel(8'd200, 8'd0,   8'd255, 1'b1));
    send_pixel(pixel(8'd7,   8'd7,   8'd200, 1'b0));
    send_pixel(pixel(8'd3,   8'd9,   8'd100, 1'b0));
    send_pixel(pixel(8'd7,   8'd1,   8'd100, 1'b0));
    send_pixel(pixel(8'd250, 8'd9,   8'd0,   1'b1));
    wait_results_drained();
  endtask

  // Odd count with duplicates and bins at both ends of the range.
  task automatic test_odd_patch();
    send_pixel(pixel(8'd255, 8'd0,   8'd128, 1'b0));
    send_pixel(pixel(8'd0,   8'd255, 8'd128, 1'b0));
    send_pixel(pixel(8'd255, 8'd0,   8'd127, 1'b0));
    send_pixel(pixel(8'd0,   8'd255, 8'd129, 1'b0));
    send_pixel(pixel(8'd128, 8'd128, 8'd128, 1'b1));
    wait_results_drained();
  endtask

  // Capacity: exactly full, then one over with the last pixel dropped,
  // then several over with clustered levels.
  task automatic test_capacity_overflow();
    send_patch(MAX_SAMPLES, 255);
    send_patch(MAX_SAMPLES + 1, 255);
    send_patch(MAX_SAMPLES + 7, $urandom_range(1, 15));
    wait_results_drained();
  endtask

  // Receiver holds off long enough for one result to sit in the output
  // register and the next walk to finish behind it, so in_ready drops
  // while the sender keeps offering pixels.
  task automatic test_output_stall();
    send_gap_pct = 0;
    hold_request = HOLD_CYCLES;
    send_patch(8, 255);
    send_patch(5, 3);
    send_patch(12, 255);
    send_patch(3, 0);
    wait_results_drained();
  endtask

  // Mostly short patches, now and then a mid-size or near-capacity one,
  // and the odd pause until the block has emptied.
  task automatic test_random_patches(input int unsigned pixel_budget);
    int unsigned sent;
    int unsigned len;
    int unsigned roll;
    int unsigned spread;
    sent = 0;
    while (sent < pixel_budget) begin
      roll = $urandom_range(99);
      if (roll < 3) begin
        len = $urandom_range(MAX_SAMPLES - 8, MAX_SAMPLES + 12);
      end else if (roll < 20) begin
        len = $urandom_range(17, 64);
      end else begin
        len = $urandom_range(1, 16);
      end
      case ($urandom_range(2))
        0:       spread = 255;
        1:       spread = $urandom_range(1, 15);
        default: spread = 0;
      endcase
      send_patch(len, spread);
      sent += len;
      if ($urandom_range(9) == 0) begin
        wait_results_drained();
      end
    end
    wait_results_drained();
  endtask

  // ---------------------------------------------------------------------
  // Sequence
  // ---------------------------------------------------------------------
  initial begin
    repeat (RST_CYCLES) @(posedge clk);
    rst_n <= 1'b1;

    // Sender idles a little, receiver a lot.
    send_gap_pct = 15;
    recv_gap_pct = 45;
    test_single_pixel_patches();
    test_even_patches();
    test_odd_patch();
    test_capacity_overflow();
    test_random_patches(30);

    test_output_stall();

    // Roles swapped.
    send_gap_pct = 45;
    recv_gap_pct = 15;
    test_random_patches(30);

    // Flat out on both sides.
    send_gap_pct = 0;
    recv_gap_pct = 0;
    test_random_patches(30);

    // Anything late would land in the final walk window.
    repeat (WALK_CYCLES) @(posedge clk);
    if (mismatches == 0 && expected_medians.size() == 0) begin
      $display("** patch_channel_median_core: PASSED **");
    end else begin
      $display("** patch_channel_median_core: FAILED **");
    end
    $finish;
  end

endmodule
